### design/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// shared types and constants of the key-value table engine
// ----------------------------------------------------------------------------
package ttl_pkg;
	localparam int SlotBits  = 10;
	localparam int TableSlots = 1 << SlotBits;
	localparam int KeyBytes  = 8;

	localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
	localparam logic [63:0] FnvPrime = 64'h00000100000001b3;
	localparam logic [47:0] ClockMax = 48'hffffffffffff;

	localparam logic [2:0] KIND_SET    = 3'd0;
	localparam logic [2:0] KIND_GET    = 3'd1;
	localparam logic [2:0] KIND_DEL    = 3'd2;
	localparam logic [2:0] KIND_EXISTS = 3'd3;
	localparam logic [2:0] KIND_EXPIRE = 3'd4;
	localparam logic [2:0] KIND_TTL    = 3'd5;
	localparam logic [2:0] KIND_TICK   = 3'd6;
	localparam logic [2:0] KIND_NONE   = 3'd7;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// entry record: mark, key_len, key, value_len, value, has_deadline, deadline
	localparam int EntryW = 2 + 4 + 64 + 4 + 64 + 1 + 48;

	typedef struct packed {
		logic [1:0]  mark;
		logic [3:0]  key_len;
		logic [63:0] key;
		logic [3:0]  value_len;
		logic [63:0] value;
		logic        has_dl;
		logic [47:0] deadline;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input item
		logic hash_step;  // one fnv byte step
		logic mul_lo;     // first partial product
		logic mul_hi;     // finish product
		logic set_home;   // slot index from hash
		logic examine;    // look at read data
		logic advance;    // next slot
		logic wr;         // write back entry
		logic finish;     // build result
		logic clr_step;   // clearing pass write
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hash_done;
		logic probe_stop;
		logic probe_end;
		logic clr_done;
		logic is_tick;
		logic is_nop;
	} dp_sts_t;
endpackage

### design/ttl_ram.sv
// ----------------------------------------------------------------------------
// ttl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ttl_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### design/ttl_datapath.sv
// ----------------------------------------------------------------------------
// ttl_datapath
// hash unit, probe walker, entry table and result build
// ----------------------------------------------------------------------------
module ttl_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ttl_pkg::dp_cmd_t     cmd,
	output ttl_pkg::dp_sts_t     sts,
	input  logic [10:0]          max_entries_q,
	input  logic [2:0]           kind,
	input  logic [63:0]          key,
	input  logic [3:0]           key_len,
	input  logic [63:0]          value,
	input  logic [3:0]           value_len,
	input  logic [30:0]          ttl_ms,
	input  logic                 ttl_given,
	output logic [1:0]           status_q,
	output logic [63:0]          value_out_q,
	output logic [3:0]           value_len_out_q,
	output logic [31:0]          ttl_left_q
);
	import ttl_pkg::*;

	logic [2:0]  kind_q;
	logic [63:0] key_q, value_q;
	logic [3:0]  kl_q, vl_q;
	logic [30:0] ttl_q;
	logic        given_q;
	logic [63:0] hash_q, lo_q;
	logic [23:0] x_q;
	logic [3:0]  hcnt_q;
	logic [SlotBits-1:0] idx_q, tomb_q;
	logic [SlotBits:0]   pcnt_q;
	logic        have_tomb_q, hit_q;
	logic [10:0] live_q;
	logic [47:0] clock_q;
	logic        clr_busy_q;
	logic [SlotBits:0] clr_cnt_q;
	entry_t      rd_e, wr_e, hit_e;
	logic        we;
	logic [SlotBits-1:0] addr;
	logic        hexp;
	logic [1:0]  st_c;
	logic        do_wr;
	logic [SlotBits-1:0] wslot;

	function automatic logic [63:0] bmask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) m[i*8 +: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [30:0] b);
		logic [48:0] s;
		s = {1'b0, a} + 49'(b);
		return s[48] ? ClockMax : s[47:0];
	endfunction

	logic [3:0] kl_c, vl_c;
	assign kl_c = (key_len > 4'(KeyBytes)) ? 4'(KeyBytes) : key_len;
	assign vl_c = (value_len > 4'd8) ? 4'd8 : value_len;

	// hash: x = h ^ byte; h = x * prime, split as x*0x1b3 + (x<<40)
	logic [63:0] xb;
	assign xb = hash_q ^ {56'd0, key_q[hcnt_q[2:0]*8 +: 8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			clock_q    <= '0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (SlotBits+1)'(TableSlots - 1)) clr_busy_q <= 1'b0;
			end
			if (cmd.load && kind == KIND_TICK) clock_q <= add_sat(clock_q, ttl_ms);
			// only an actual table write changes the live count
			if (cmd.wr && do_wr) begin
				if (kind_q == KIND_SET) begin
					if (!hit_q) live_q <= live_q + 1'b1;
				end else if (kind_q != KIND_EXPIRE && live_q != '0) begin
					live_q <= live_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			kl_q    <= kl_c;
			vl_q    <= vl_c;
			key_q   <= key & bmask(kl_c);
			value_q <= value & bmask(vl_c);
			ttl_q   <= ttl_ms;
			given_q <= ttl_given;
			hash_q  <= FnvBasis;
			hcnt_q  <= '0;
		end
		if (cmd.mul_lo) begin
			x_q  <= xb[23:0];
			lo_q <= xb * 64'h1b3;
		end
		if (cmd.mul_hi) begin
			hash_q <= lo_q + {x_q, 40'd0};
			hcnt_q <= hcnt_q + 1'b1;
		end
		if (cmd.set_home) begin
			idx_q       <= hash_q[SlotBits-1:0];
			pcnt_q      <= '0;
			have_tomb_q <= 1'b0;
			hit_q       <= 1'b0;
		end
		if (cmd.examine) begin
			pcnt_q <= pcnt_q + 1'b1;
			if (rd_e.mark == MARK_EMPTY) begin
				if (!have_tomb_q) tomb_q <= idx_q;
				have_tomb_q <= 1'b1;
			end else if (rd_e.mark == MARK_TOMB) begin
				if (!have_tomb_q) begin
					tomb_q <= idx_q;
					have_tomb_q <= 1'b1;
				end
			end else if (rd_e.key_len == kl_q && rd_e.key == key_q) begin
				hit_q <= 1'b1;
				hit_e <= rd_e;
			end
		end
		if (cmd.advance) idx_q <= idx_q + 1'b1;
	end

	// probe stops at empty or match; end after full walk
	assign sts.hash_done  = (hcnt_q == kl_q);
	assign sts.probe_stop = (rd_e.mark == MARK_EMPTY) ||
		(rd_e.mark == MARK_USED && rd_e.key_len == kl_q && rd_e.key == key_q);
	assign sts.probe_end  = (pcnt_q == (SlotBits+1)'(TableSlots - 1));
	assign sts.clr_done   = !clr_busy_q;
	assign sts.is_tick    = (kind == KIND_TICK);
	assign sts.is_nop     = (kind == KIND_NONE);

	// decide write and status after probe
	assign hexp = hit_e.has_dl && (clock_q >= hit_e.deadline);
	always_comb begin
		wr_e  = hit_e;
		st_c  = ST_OK;
		do_wr = 1'b0;
		wslot = hit_q ? idx_q : tomb_q;
		case (kind_q)
			KIND_SET: begin
				if (!hit_q && (!have_tomb_q || live_q >= max_entries_q)) begin
					st_c = ST_FULL;
				end else begin
					do_wr = 1'b1;
					if (!hit_q) begin
						wr_e.mark    = MARK_USED;
						wr_e.key     = key_q;
						wr_e.key_len = kl_q;
					end
					wr_e.value     = value_q;
					wr_e.value_len = vl_q;
					wr_e.has_dl    = given_q;
					wr_e.deadline  = given_q ? add_sat(clock_q, ttl_q) : 48'd0;
				end
			end
			KIND_GET, KIND_EXISTS: begin
				if (!hit_q) st_c = ST_MISS;
				else if (hexp) begin
					st_c = ST_MISS;
					do_wr = 1'b1;
					wr_e.mark = MARK_TOMB;
				end
			end
			KIND_DEL: begin
				if (!hit_q) st_c = ST_MISS;
				else begin
					st_c = hexp ? ST_MISS : ST_OK;
					do_wr = 1'b1;
					wr_e.mark = MARK_TOMB;
				end
			end
			KIND_EXPIRE: begin
				if (!hit_q || hexp) st_c = ST_MISS;
				else begin
					do_wr = 1'b1;
					wr_e.has_dl = 1'b1;
					wr_e.deadline = add_sat(clock_q, ttl_q);
				end
			end
			KIND_TTL: begin
				if (!hit_q || hexp) st_c = ST_MISS;
			end
			default: st_c = ST_OK;
		endcase
	end

	logic [47:0] rem;
	assign rem = hit_e.deadline - clock_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q        <= ST_OK;
			value_out_q     <= '0;
			value_len_out_q <= '0;
			ttl_left_q      <= '0;
		end
		if (cmd.finish) begin
			status_q <= st_c;
			if (kind_q == KIND_GET && st_c == ST_OK) begin
				value_out_q     <= hit_e.value;
				value_len_out_q <= hit_e.value_len;
			end
			if (kind_q == KIND_TTL) begin
				if (st_c != ST_OK) ttl_left_q <= 32'hffff_fffe;
				else if (!hit_e.has_dl) ttl_left_q <= 32'hffff_ffff;
				else if (rem > 48'h7fff_ffff) ttl_left_q <= 32'h7fff_ffff;
				else ttl_left_q <= rem[31:0];
			end
		end
	end

	// when hit, idx_q still points at the matching slot (no advance on stop)
	assign we   = cmd.clr_step || (cmd.wr && do_wr);
	assign addr = cmd.clr_step ? clr_cnt_q[SlotBits-1:0] : (cmd.wr ? wslot : idx_q);

	entry_t wdata;
	always_comb begin
		wdata = wr_e;
		if (cmd.clr_step) wdata = '0;
	end

	ttl_ram #(.Width(EntryW), .Depth(TableSlots)) u_tab (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rd_e)
	);
endmodule

### design/ttl_ctrl.sv
// ----------------------------------------------------------------------------
// ttl_ctrl
// sequencer for clearing, hashing, probing and write back
// ----------------------------------------------------------------------------
module ttl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	output ttl_pkg::dp_cmd_t  cmd,
	input  ttl_pkg::dp_sts_t  sts
);
	import ttl_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HX   = 4'd2;
	localparam logic [3:0] S_HM   = 4'd3;
	localparam logic [3:0] S_HOME = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_WAIT = 4'd6;
	localparam logic [3:0] S_EX   = 4'd7;
	localparam logic [3:0] S_WR   = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;
	localparam logic [3:0] S_HCHK = 4'd10;

	logic [3:0] state_q, state_d;
	logic       ov_q, ov_d;
	logic       take, xfer;

	assign out_valid = ov_q;
	assign xfer      = ov_q && !out_stall;
	assign in_stall  = !(state_q == S_IDLE && (!ov_q || !out_stall));
	assign take      = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ov_d    = ov_q && !xfer;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (take) begin
					cmd.load = 1'b1;
					if (sts.is_tick || sts.is_nop) ov_d = 1'b1;
					else state_d = S_HCHK;
				end
			end
			S_HCHK: state_d = sts.hash_done ? S_HOME : S_HX;
			S_HX: begin
				cmd.mul_lo = 1'b1;
				state_d = S_HM;
			end
			S_HM: begin
				cmd.mul_hi = 1'b1;
				state_d = S_HCHK;
			end
			S_HOME: begin
				cmd.set_home = 1'b1;
				state_d = S_RD;
			end
			// ram address follows the slot index
			S_RD: state_d = S_WAIT;
			S_WAIT: state_d = S_EX;
			S_EX: begin
				cmd.examine = 1'b1;
				if (sts.probe_stop || sts.probe_end) state_d = S_WR;
				else begin
					cmd.advance = 1'b1;
					state_d = S_RD;
				end
			end
			S_WR: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.wr = 1'b1;
				ov_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

`ifndef SYNTH
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("result dropped");
	a_wr_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> ov_q) else $error("write back without result");
`endif
endmodule

### design/ttl_hash_table_linear_probe.sv
// ----------------------------------------------------------------------------
// ttl_hash_table_linear_probe
// key-value table with fnv-1a hashing, linear probing and lazy ttl expiry
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_stall with kind, key, key_len, value, value_len,
//   ttl_ms, ttl_given; one result per item on out_valid/out_stall. config channel:
//   cfg_valid/cfg_ready writes max_entries; user only while idle, not enforced.
// operation:
//   tick and unused kinds: result in the cycle after the transfer.
//   others: each key byte is hashed (check and two multiply halves), then
//   slots are visited from the home slot (table ram read), then the result
//   is built and written back. one item at a time: the next item is taken
//   at the earliest on the edge where the previous result transfers.
// reset:
//   after arst_n rises, a clearing pass writes all 1024 table slots, one
//   per cycle; no input is taken until the clearing pass is done.
// stall:
//   the result stays in its output register and the input is stalled
//   until that result transfers.
// ----------------------------------------------------------------------------
module ttl_hash_table_linear_probe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [63:0] key,
	input  logic [3:0]  key_len,
	input  logic [63:0] value,
	input  logic [3:0]  value_len,
	input  logic [30:0] ttl_ms,
	input  logic        ttl_given,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] value_out,
	output logic [3:0]  value_len_out,
	output logic [31:0] ttl_left,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	import ttl_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [10:0] max_entries_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 11'd716;
		end else if (cfg_valid) begin
			max_entries_q <= cfg_data;
		end
	end

	ttl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	ttl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.max_entries_q   (max_entries_q),
		.kind            (kind),
		.key             (key),
		.key_len         (key_len),
		.value           (value),
		.value_len       (value_len),
		.ttl_ms          (ttl_ms),
		.ttl_given       (ttl_given),
		.status_q        (status),
		.value_out_q     (value_out),
		.value_len_out_q (value_len_out),
		.ttl_left_q      (ttl_left)
	);
endmodule
